>>> design/d2q9_pkg.sv
// ----------------------------------------------------------------------------
// d2q9_pkg
// Shared types, constants and direction tables for the D2Q9 node block.
// ----------------------------------------------------------------------------
package d2q9_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_DIRS      = 9;
  localparam int DIR_W         = 4;
  localparam int VAL_W         = 32;
  localparam int ADDR_W        = 4;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_INIT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // direction vector component: -1, 0, +1
  function automatic logic signed [1:0] dir_ex(input logic [DIR_W-1:0] k);
    case (k)
      4'd1, 4'd5, 4'd8: dir_ex = 2'sd1;
      4'd3, 4'd6, 4'd7: dir_ex = -2'sd1;
      default:          dir_ex = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_ey(input logic [DIR_W-1:0] k);
    case (k)
      4'd2, 4'd5, 4'd6: dir_ey = 2'sd1;
      4'd4, 4'd7, 4'd8: dir_ey = -2'sd1;
      default:          dir_ey = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -96'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

endpackage

>>> design/d2q9_div.sv
// ----------------------------------------------------------------------------
// d2q9_div
// Radix-2 restoring divider, signed operands, quotient truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module d2q9_div
  import d2q9_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic [63:0] n_mag_r, n_mag_nxt;
  logic [31:0] d_mag_r, d_mag_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic signed [95:0] qs;

  always_comb begin
    n_mag_nxt = n_mag_r;
    d_mag_nxt = d_mag_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    shifted   = {rem_r[63:0], n_mag_r[63]};
    if (start) begin
      n_mag_nxt = num[63] ? 64'(-num) : 64'(num);
      d_mag_nxt = den[31] ? 32'(-den) : 32'(den);
      neg_nxt   = num[63] ^ den[31];
      rem_nxt   = '0;
      q_nxt     = '0;
      cnt_nxt   = 7'd64;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      n_mag_nxt = {n_mag_r[62:0], 1'b0};
      if (shifted >= {33'd0, d_mag_r}) begin
        rem_nxt = shifted - {33'd0, d_mag_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_mag_r <= n_mag_nxt;
    d_mag_r <= d_mag_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
  end

  assign qs   = neg_r ? -$signed({32'd0, q_r}) : $signed({32'd0, q_r});
  assign quo  = sat32(qs);
  assign done = done_r;

endmodule

>>> design/d2q9_feq.sv
// ----------------------------------------------------------------------------
// d2q9_feq
// Equilibrium datapath for one direction, six register stages, one squarer
// in stage two; the final divide by 9 is a reciprocal multiply, done as two
// partial products in the last stage after the dividend is scaled.
// ----------------------------------------------------------------------------
module d2q9_feq
  import d2q9_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [DIR_W-1:0]   k_in,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] rho,
  input  logic signed [63:0] usq,
  output logic               out_vld,
  output logic [DIR_W-1:0]   k_out,
  output logic signed [31:0] feq
);

  logic signed [63:0] eu_full;
  logic signed [31:0] eu_s1_r;
  logic [DIR_W-1:0]   k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic [5:0]         v_r;
  logic signed [63:0] eusq2_r;
  logic signed [31:0] eu2_r;
  logic signed [31:0] br3_r;
  logic signed [63:0] t4_r;
  logic signed [95:0] br_sum;
  logic signed [63:0] eu2_q;
  logic signed [63:0] t_full;
  logic [63:0]        t_mag;
  logic [36:0]        num_c;
  logic [36:0]        num5_r;
  logic               neg5_r, neg6_r;
  logic [56:0]        pl6_r;
  logic [55:0]        ph6_r;
  logic [75:0]        prod;
  logic [34:0]        q6;
  logic signed [95:0] qs;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  // ceil(2^41 / 9): exact floor(x / 9) for x below 2^39
  localparam logic [37:0] RECIP9  = 38'd244335917284;
  localparam logic [36:0] NUM_MAX = 37'h1f_ffff_ffff;
  // above these magnitudes the result saturates anyway
  localparam logic [63:0] CAP_K0  = 64'd34359738368;
  localparam logic [63:0] CAP_K   = 64'd137438953472;

  always_comb begin
    eu_full = 64'sd0;
    if (dir_ex(k_in) == 2'sd1)       eu_full = eu_full + 64'(vx);
    else if (dir_ex(k_in) == -2'sd1) eu_full = eu_full - 64'(vx);
    if (dir_ey(k_in) == 2'sd1)       eu_full = eu_full + 64'(vy);
    else if (dir_ey(k_in) == -2'sd1) eu_full = eu_full - 64'(vy);
  end

  assign eu2_q  = eusq2_r / ONE;
  assign br_sum = 96'(ONE) + 96'sd3 * 96'(eu2_r) + (96'(eu2_q) * 96'sd9) / 96'sd2
                  - (96'(usq) * 96'sd3) / 96'sd2;
  assign t_full = (64'(rho) * 64'(br3_r)) / ONE;

  // magnitude of the dividend: 4t for rest, t for axes, t/4 for diagonals
  assign t_mag = t4_r[63] ? 64'(-t4_r) : 64'(t4_r);

  always_comb begin
    case (k4_r)
      4'd0:                   num_c = (t_mag >= CAP_K0) ? NUM_MAX : {t_mag[34:0], 2'b00};
      4'd1, 4'd2, 4'd3, 4'd4: num_c = (t_mag >= CAP_K) ? NUM_MAX : t_mag[36:0];
      default:                num_c = (t_mag >= CAP_K) ? NUM_MAX : {2'b00, t_mag[36:2]};
    endcase
  end

  assign prod = 76'({ph6_r, 19'd0}) + 76'(pl6_r);
  assign q6   = prod[75:41];
  assign qs   = $signed({61'd0, q6});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_vld};
    end
    eu_s1_r <= sat32(96'(eu_full));
    k1_r    <= k_in;
    eusq2_r <= 64'(eu_s1_r) * 64'(eu_s1_r);
    eu2_r   <= eu_s1_r;
    k2_r    <= k1_r;
    br3_r   <= sat32(br_sum);
    k3_r    <= k2_r;
    t4_r    <= t_full;
    k4_r    <= k3_r;
    num5_r  <= num_c;
    neg5_r  <= t4_r[63];
    k5_r    <= k4_r;
    pl6_r   <= 57'(num5_r[18:0]) * 57'(RECIP9);
    ph6_r   <= 56'(num5_r[36:19]) * 56'(RECIP9);
    neg6_r  <= neg5_r;
    k6_r    <= k5_r;
  end

  assign out_vld = v_r[5];
  assign k_out   = k6_r;
  assign feq     = sat32(neg6_r ? -qs : qs);

endmodule

>>> design/d2q9_moments_and_equilibrium.sv
// ----------------------------------------------------------------------------
// d2q9_moments_and_equilibrium
// One D2Q9 node: distribution store, moments, velocity divide, equilibrium.
// ----------------------------------------------------------------------------
// A load never raises busy. Compute reads the nine-entry store one entry a
// cycle, runs two 64-bit serial divides with the S_WX setup state between,
// then issues one direction a cycle into a 6-stage equilibrium pipe; the
// divides are skipped when the density is zero. Init skips the sum and the
// divides. Results come out one per cycle on out_valid and cannot be
// stalled; busy drops in the cycle that carries the last one.
module d2q9_moments_and_equilibrium
  import d2q9_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_dir_index,
  input  logic signed [31:0] in_dist_value,
  input  logic signed [31:0] in_init_vel_x,
  input  logic signed [31:0] in_init_vel_y,
  input  logic signed [31:0] in_init_density,
  output logic               out_valid,
  output logic [3:0]         out_index,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_vel_x_out,
  output logic signed [31:0] out_vel_y_out,
  output logic signed [31:0] out_density_out,
  output logic               out_last
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SUM  = 8'b00000010,
    S_DIVX = 8'b00000100,
    S_WX   = 8'b00001000,
    S_DIVY = 8'b00010000,
    S_WY   = 8'b00100000,
    S_ISS  = 8'b01000000,
    S_DRN  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] mem [NUM_DIRS];
  logic signed [31:0] rd_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               rd_vld_r;
  logic [ADDR_W-1:0]  rd_k_r;

  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic signed [35:0] rho_r, rho_nxt, mx_r, mx_nxt, my_r, my_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt, den_r, den_nxt;
  logic signed [63:0] usq_r;
  logic               store_r, store_nxt;
  logic               dstart;
  logic signed [63:0] dnum;
  logic               ddone;
  logic signed [31:0] dquo;
  logic               fvld;
  logic [DIR_W-1:0]   fk;
  logic signed [31:0] fval;
  logic               accept;
  logic signed [31:0] f_term;
  logic [63:0]        sq_sum;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign f_term = rd_r;
  assign sq_sum = 64'(vx_r * 64'(vx_r)) + 64'(64'(vy_r) * 64'(vy_r));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rho_nxt   = rho_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    den_nxt   = den_r;
    store_nxt = store_r;
    rd_en     = 1'b0;
    rd_addr   = cnt_r;
    dstart    = 1'b0;
    dnum      = 64'(mx_r) <<< FRAC_BITS;
    if (rd_vld_r) begin
      rho_nxt = rho_r + 36'(f_term);
      if (dir_ex(rd_k_r) == 2'sd1)       mx_nxt = mx_r + 36'(f_term);
      else if (dir_ex(rd_k_r) == -2'sd1) mx_nxt = mx_r - 36'(f_term);
      if (dir_ey(rd_k_r) == 2'sd1)       my_nxt = my_r + 36'(f_term);
      else if (dir_ey(rd_k_r) == -2'sd1) my_nxt = my_r - 36'(f_term);
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_COMPUTE: begin
              state_nxt = S_SUM;
              cnt_nxt   = '0;
              rho_nxt   = '0;
              mx_nxt    = '0;
              my_nxt    = '0;
              store_nxt = 1'b0;
            end
            CMD_INIT: begin
              vx_nxt    = in_init_vel_x;
              vy_nxt    = in_init_vel_y;
              den_nxt   = in_init_density;
              store_nxt = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_WY;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SUM: begin
        if (cnt_r < ADDR_W'(NUM_DIRS)) begin
          rd_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          den_nxt = sat32(96'(rho_r));
          if (sat32(96'(rho_r)) != 32'sd0) begin
            dstart    = 1'b1;
            state_nxt = S_DIVX;
          end else begin
            state_nxt = S_WY;
          end
          cnt_nxt = '0;
        end
      end
      S_DIVX: if (ddone) begin
        vx_nxt    = dquo;
        state_nxt = S_WX;
      end
      S_WX: begin
        dnum      = 64'(my_r) <<< FRAC_BITS;
        dstart    = 1'b1;
        state_nxt = S_DIVY;
      end
      S_DIVY: if (ddone) begin
        vy_nxt    = dquo;
        state_nxt = S_WY;
      end
      S_WY: state_nxt = S_ISS;   // usq register settles
      S_ISS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_W'(NUM_DIRS - 1)) state_nxt = S_DRN;
      end
      S_DRN: if (fvld && fk == DIR_W'(NUM_DIRS - 1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // divisor taken from the next-state value: density lands in den_r on the
  // same edge that starts the first divide
  d2q9_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dstart),
    .num  (dnum),
    .den  (den_nxt),
    .done (ddone),
    .quo  (dquo)
  );

  d2q9_feq #(.FRAC_BITS(FRAC_BITS)) u_feq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (state_r == S_ISS),
    .k_in   (cnt_r),
    .vx     (vx_r),
    .vy     (vy_r),
    .rho    (den_r),
    .usq    (usq_r),
    .out_vld(fvld),
    .k_out  (fk),
    .feq    (fval)
  );

  // store: load write and init write-back share the single write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIRS; i++) mem[i] <= '0;
    end else if (accept && cmd_t'(in_command) == CMD_LOAD &&
                 in_dir_index < 4'(NUM_DIRS)) begin
      mem[in_dir_index] <= in_dist_value;
    end else if (fvld && store_r) begin
      mem[fk] <= fval;
    end
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      cnt_r    <= '0;
      vx_r     <= '0;
      vy_r     <= '0;
      den_r    <= '0;
      store_r  <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      cnt_r    <= cnt_nxt;
      vx_r     <= vx_nxt;
      vy_r     <= vy_nxt;
      den_r    <= den_nxt;
      store_r  <= store_nxt;
      out_valid <= fvld;
      out_last  <= fvld && fk == DIR_W'(NUM_DIRS - 1);
    end
    rd_k_r <= rd_addr;
    rho_r  <= rho_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    usq_r  <= $signed(sq_sum >> FRAC_BITS);
    out_index       <= fk;
    out_value       <= fval;
    out_vel_x_out   <= vx_r;
    out_vel_y_out   <= vy_r;
    out_density_out <= den_r;
  end

`ifndef ASSERT_OFF
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid && out_index == DIR_W'(NUM_DIRS - 1))
    else $error("last on wrong index");
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ddone |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider done outside divide");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fvld && fk == DIR_W'(NUM_DIRS - 1)) |=> !busy)
    else $error("busy after last");
`endif

endmodule
